@@ rtl/att_pkg.sv @@
package att_pkg;

    // Table geometry and register defaults
    localparam int SLOT_COUNT_DEF = 16;
    localparam int SLOT_COUNT_MAX = 64;
    localparam logic [31:0] EXPIRY_RESET = 32'd80;

    // Field widths
    localparam int OWNER_W = 16;
    localparam int KIND_W  = 2;
    localparam int TICK_W  = 32;
    localparam int SLOT_W  = 4;
    localparam int ENTRY_W = OWNER_W + KIND_W + TICK_W;

    // Stream payload widths
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    // Input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    // Result kinds
    localparam logic [1:0] RES_SET_REPLY = 2'd0;
    localparam logic [1:0] RES_EXPIRY    = 2'd1;
    localparam logic [1:0] RES_TICK_DONE = 2'd2;

    // Set reply status codes
    localparam logic [1:0] SET_RESTARTED = 2'd0;
    localparam logic [1:0] SET_ALLOCATED = 2'd1;
    localparam logic [1:0] SET_IGNORED   = 2'd2;
    localparam logic [1:0] SET_FULL      = 2'd3;

endpackage

@@ rtl/att_ram.sv @@
module att_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/alarm_timer_table_unit.sv @@
// Alarm timer table: a tick counter and a table of one-shot alarm slots.
// Input beats arrive on s_axis. tuser selects the operation: a tick, or a set
// (arm or restart) for the owner and timer kind in tdata. Result beats leave on
// m_axis; tuser carries the result kind and tlast marks the final beat of the
// input beat that caused them.
// A set produces one reply beat. A tick produces one expiry beat for every
// armed slot whose elapsed tick count reached expiry_ticks, then a done beat.
// One input beat is worked on at a time. The slot table lives in a
// synchronous RAM that is read one slot per cycle unless a stalled result
// holds the scan; a set stops at its matching slot, and a set that ignores
// its request skips the scan.
// A new input beat is taken as soon as the last result sits in the output
// register, even while that beat still waits for the receiver.
// When the receiver stalls, the output register holds its beat and the slot
// scan pauses on the slot that wants to emit; nothing is dropped.
// Reset empties the table (all slots free), clears the tick counter and loads
// expiry_ticks with 80. cfg_we writes expiry_ticks; write it only while idle.
module alarm_timer_table_unit
    import att_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration: expiry_ticks
    input  logic                  cfg_we,
    input  logic [TICK_W-1:0]     cfg_wdata,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // owner_id[15:0], timer_kind[17:16],
                                                 // value_is_zero[18], zero pad
    input  logic                  s_axis_tuser,  // operation
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // set_status[1:0], fired_owner[17:2],
                                                 // slot_index[21:18], zero pad
    output logic [1:0]            m_axis_tuser,  // result_kind
    output logic                  m_axis_tlast   // last
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_REPLY = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic                  op_reg, op_next;
    logic [OWNER_W-1:0]    owner_reg, owner_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [TICK_W-1:0]     expiry_reg, expiry_next;
    logic [SLOT_COUNT-1:0] valid_reg, valid_next;

    // Scan pipeline: read address counter and evaluate stage
    logic [CNT_W-1:0]      rd_idx_reg, rd_idx_next;
    logic                  e_vld_reg, e_vld_next;
    logic [IDX_W-1:0]      e_idx_reg, e_idx_next;

    // Pending reply for the final beat
    logic [1:0]            rep_kind_reg, rep_kind_next;
    logic [1:0]            rep_status_reg, rep_status_next;
    logic [SLOT_W-1:0]     rep_slot_reg, rep_slot_next;

    // Output register
    logic                  out_vld_reg, out_vld_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic [OWNER_W-1:0]    out_owner_reg, out_owner_next;
    logic [SLOT_W-1:0]     out_slot_reg, out_slot_next;
    logic                  out_last_reg, out_last_next;

    // RAM port
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

    logic [OWNER_W-1:0]    rd_owner;
    logic [KIND_W-1:0]     rd_kind;
    logic [TICK_W-1:0]     rd_start;
    logic [TICK_W-1:0]     elapsed;
    logic                  e_armed, fire, hit, emit_need, out_free, advance;
    logic                  in_accept;
    logic                  free_any;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W+SLOT_W-1:0] e_idx_ext, free_idx_ext;

    att_ram
    #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    )
    u_slot_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry layout: owner in the low bits, then kind, then start tick
    assign rd_owner = ram_rdata[OWNER_W-1:0];
    assign rd_kind  = ram_rdata[OWNER_W +: KIND_W];
    assign rd_start = ram_rdata[OWNER_W+KIND_W +: TICK_W];

    assign elapsed   = tick_reg - rd_start;
    assign e_armed   = e_vld_reg && valid_reg[e_idx_reg];
    assign fire      = e_armed && (elapsed >= expiry_reg);
    assign hit       = e_armed && (rd_owner == owner_reg) && (rd_kind == kind_reg);
    assign emit_need = (op_reg == OP_TICK) ? fire : hit;
    assign out_free  = !out_vld_reg || m_axis_tready;
    assign advance   = !emit_need || out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Slot index as reported: low four bits of the table index
    assign e_idx_ext    = (IDX_W+SLOT_W)'(e_idx_reg);
    assign free_idx_ext = (IDX_W+SLOT_W)'(free_idx);

    // Lowest free slot
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        owner_next      = owner_reg;
        kind_next       = kind_reg;
        tick_next       = tick_reg;
        expiry_next     = cfg_we ? cfg_wdata : expiry_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        e_vld_next      = e_vld_reg;
        e_idx_next      = e_idx_reg;
        rep_kind_next   = rep_kind_reg;
        rep_status_next = rep_status_reg;
        rep_slot_next   = rep_slot_reg;
        out_vld_next    = out_vld_reg && !m_axis_tready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_owner_next  = out_owner_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = e_idx_reg;
        ram_wdata       = {tick_reg, kind_reg, owner_reg};
        ram_re          = 1'b0;
        ram_raddr       = rd_idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next     = s_axis_tuser;
                    owner_next  = s_axis_tdata[OWNER_W-1:0];
                    kind_next   = s_axis_tdata[OWNER_W +: KIND_W];
                    rd_idx_next = '0;
                    e_vld_next  = 1'b0;
                    if (s_axis_tuser == OP_TICK)
                    begin
                        tick_next  = tick_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                    else if (s_axis_tdata[OWNER_W+KIND_W] ||
                             (s_axis_tdata[OWNER_W-1:0] == '0))
                    begin
                        // zero value or no owner: drop the request
                        rep_kind_next   = RES_SET_REPLY;
                        rep_status_next = SET_IGNORED;
                        rep_slot_next   = '0;
                        state_next      = ST_REPLY;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (emit_need && out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_slot_next   = e_idx_ext[SLOT_W-1:0];
                    out_status_next = SET_RESTARTED;
                    if (op_reg == OP_TICK)
                    begin
                        out_kind_next  = RES_EXPIRY;
                        out_owner_next = rd_owner;
                        out_last_next  = 1'b0;
                        valid_next[e_idx_reg] = 1'b0;
                    end
                    else
                    begin
                        // restart the matching slot and finish
                        out_kind_next  = RES_SET_REPLY;
                        out_owner_next = '0;
                        out_last_next  = 1'b1;
                        ram_we         = 1'b1;
                        e_vld_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end

                if (advance && !(op_reg == OP_SET && hit))
                begin
                    if (rd_idx_reg != CNT_W'(SLOT_COUNT))
                    begin
                        ram_re      = 1'b1;
                        e_vld_next  = 1'b1;
                        e_idx_next  = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next = rd_idx_reg + 1'b1;
                    end
                    else
                    begin
                        e_vld_next = 1'b0;
                    end
                end

                // every slot seen: prepare the closing beat
                if ((rd_idx_reg == CNT_W'(SLOT_COUNT)) && !e_vld_reg)
                begin
                    state_next = ST_REPLY;
                    if (op_reg == OP_TICK)
                    begin
                        rep_kind_next   = RES_TICK_DONE;
                        rep_status_next = SET_RESTARTED;
                        rep_slot_next   = '0;
                    end
                    else if (free_any)
                    begin
                        ram_we               = 1'b1;
                        ram_waddr            = free_idx;
                        valid_next[free_idx] = 1'b1;
                        rep_kind_next        = RES_SET_REPLY;
                        rep_status_next      = SET_ALLOCATED;
                        rep_slot_next        = free_idx_ext[SLOT_W-1:0];
                    end
                    else
                    begin
                        rep_kind_next   = RES_SET_REPLY;
                        rep_status_next = SET_FULL;
                        rep_slot_next   = '0;
                    end
                end
            end

            ST_REPLY:
            begin
                if (out_free)
                begin
                    out_vld_next    = 1'b1;
                    out_kind_next   = rep_kind_reg;
                    out_status_next = rep_status_reg;
                    out_owner_next  = '0;
                    out_slot_next   = rep_slot_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_TICK;
            owner_reg      <= '0;
            kind_reg       <= '0;
            tick_reg       <= '0;
            expiry_reg     <= EXPIRY_RESET;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            e_vld_reg      <= 1'b0;
            e_idx_reg      <= '0;
            rep_kind_reg   <= RES_SET_REPLY;
            rep_status_reg <= SET_RESTARTED;
            rep_slot_reg   <= '0;
            out_vld_reg    <= 1'b0;
            out_kind_reg   <= RES_SET_REPLY;
            out_status_reg <= SET_RESTARTED;
            out_owner_reg  <= '0;
            out_slot_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            owner_reg      <= owner_next;
            kind_reg       <= kind_next;
            tick_reg       <= tick_next;
            expiry_reg     <= expiry_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            e_vld_reg      <= e_vld_next;
            e_idx_reg      <= e_idx_next;
            rep_kind_reg   <= rep_kind_next;
            rep_status_reg <= rep_status_next;
            rep_slot_reg   <= rep_slot_next;
            out_vld_reg    <= out_vld_next;
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_owner_reg  <= out_owner_next;
            out_slot_reg   <= out_slot_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_slot_reg, out_owner_reg, out_status_reg};

endmodule

@@ rtl/att_chk.sv @@
module att_chk
    import att_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [M_TDATA_W-1:0]  m_axis_tdata,
    input logic [1:0]            m_axis_tuser,
    input logic                  m_axis_tlast
);

    // Stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid &&
        $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

    // Expiries are never the closing beat and always name an owner
    a_exp_shape: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == RES_EXPIRY) |->
        !m_axis_tlast && (m_axis_tdata[17:2] != '0) && (m_axis_tdata[1:0] == SET_RESTARTED))
        else $error("malformed expiry beat");

    // Replies and tick done close their item
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != RES_EXPIRY) |->
        m_axis_tlast && (m_axis_tdata[17:2] == '0) &&
        ((m_axis_tuser == RES_SET_REPLY) || (m_axis_tuser == RES_TICK_DONE)))
        else $error("malformed closing beat");

    // Ignored, full and done beats carry slot zero
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && ((m_axis_tuser == RES_TICK_DONE) ||
        ((m_axis_tuser == RES_SET_REPLY) &&
         ((m_axis_tdata[1:0] == SET_IGNORED) || (m_axis_tdata[1:0] == SET_FULL))))
        |-> (m_axis_tdata[21:18] == '0))
        else $error("slot index set on a slotless beat");

endmodule

bind alarm_timer_table_unit att_chk u_att_chk
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
